@@ hdl/sefr_pkg.sv @@
// sefr_pkg: shared constants and result type for the stx/etx frame receiver
// no dependencies; imported by sefr_out_if, the output queue and the top level
`default_nettype none

package sefr_pkg;

  localparam logic [7:0]  START_BYTE   = 8'hAA;
  localparam logic [7:0]  END_BYTE     = 8'h55;
  localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_END_BAD  = 2'd1,
    ST_SUM_BAD  = 2'd2,
    ST_TIMEOUT  = 2'd3
  } sefr_status_t;

  typedef struct packed {
    logic         result_kind;
    logic [7:0]   payload_byte;
    logic [7:0]   payload_index;
    logic [7:0]   frame_command;
    logic [7:0]   payload_length;
    sefr_status_t frame_status;
  } sefr_result_t;

endpackage

`default_nettype wire

@@ hdl/sefr_in_if.sv @@
// sefr_in_if: valid/ready channel carrying one received byte or millisecond tick
// no dependencies
`default_nettype none

interface sefr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/sefr_out_if.sv @@
// sefr_out_if: valid/ready channel carrying one payload byte or frame end result
// uses sefr_pkg for the status type
`default_nettype none

interface sefr_out_if;
  import sefr_pkg::*;
  logic         valid;
  logic         ready;
  logic         result_kind;
  logic [7:0]   payload_byte;
  logic [7:0]   payload_index;
  logic [7:0]   frame_command;
  logic [7:0]   payload_length;
  sefr_status_t frame_status;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_index, output frame_command, output payload_length,
                  output frame_status, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_index, input frame_command, input payload_length,
                  input frame_status, output ready);
endinterface

`default_nettype wire

@@ hdl/sefr_out_queue.sv @@
// sefr_out_queue: two-entry result register with skid, parts the core from the sink
// uses sefr_pkg (result type) and sefr_out_if
`default_nettype none

module sefr_out_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  sefr_pkg::sefr_result_t push_data,
  output logic                  has_room,
  sefr_out_if.source            out_if
);
  import sefr_pkg::*;

  sefr_result_t entry_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         pop;
  sefr_result_t head;

  assign pop      = out_if.valid && out_if.ready;
  assign has_room = (cnt_r != 2'd2);
  assign head     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_if.valid          = (cnt_r != 2'd0);
  assign out_if.result_kind    = head.result_kind;
  assign out_if.payload_byte   = head.payload_byte;
  assign out_if.payload_index  = head.payload_index;
  assign out_if.frame_command  = head.frame_command;
  assign out_if.payload_length = head.payload_length;
  assign out_if.frame_status   = head.frame_status;

endmodule

`default_nettype wire

@@ hdl/stx_etx_frame_receiver_core.sv @@
// stx_etx_frame_receiver_core: start/length/checksum/end deframer with ms timeout
// result path: a result is written into the two-entry result queue when the request that causes it is accepted
// throughput: one request per cycle; the two-entry result queue stalls input only
// when two results wait for the sink
// reset (rst_n, synchronous): hunting for start byte, counters cleared, limit 2000 ms
// depends on sefr_pkg, sefr_in_if, sefr_out_if, sefr_out_queue
`default_nettype none

module stx_etx_frame_receiver_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata,
  sefr_in_if.sink     in_if,
  sefr_out_if.source  out_if
);
  import sefr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_CMD   = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4,
    PH_END   = 3'd5
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [7:0]   cmd_r, cmd_nxt;
  logic [7:0]   len_r, len_nxt;
  logic [7:0]   count_r, count_nxt;
  logic [7:0]   xor_r, xor_nxt;
  logic [7:0]   check_r, check_nxt;
  logic [16:0]  elapsed_r, elapsed_nxt;
  logic [15:0]  limit_r;

  logic         accept;
  logic         room;
  logic         push;
  sefr_result_t res;
  logic         restart;
  logic [16:0]  tick_elapsed;
  logic [16:0]  limit_ext;

  assign in_if.ready = room;
  assign accept      = in_if.valid && room;
  assign limit_ext   = {1'b0, limit_r};
  assign tick_elapsed = (elapsed_r < ELAPSED_MAX) ? elapsed_r + 17'd1 : elapsed_r;

  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    check_nxt   = check_r;
    elapsed_nxt = elapsed_r;
    push        = 1'b0;
    restart     = 1'b0;
    res.result_kind    = KIND_FINAL;
    res.payload_byte   = 8'd0;
    res.payload_index  = 8'd0;
    res.frame_command  = cmd_r;
    res.payload_length = len_r;
    res.frame_status   = ST_OK;

    if (in_if.op == OP_TICK) begin
      elapsed_nxt = tick_elapsed;
      if (tick_elapsed > limit_ext) begin
        push             = 1'b1;
        restart          = 1'b1;
        res.frame_status = ST_TIMEOUT;
      end
    end else if (elapsed_r > limit_ext) begin
      // limit lowered below the time already spent: byte is dropped
      push             = 1'b1;
      restart          = 1'b1;
      res.frame_status = ST_TIMEOUT;
    end else begin
      case (phase_r)
        PH_CMD: begin
          cmd_nxt   = in_if.rx_byte;
          xor_nxt   = in_if.rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = in_if.rx_byte;
          xor_nxt   = xor_r ^ in_if.rx_byte;
          count_nxt = 8'd0;
          phase_nxt = (in_if.rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          xor_nxt   = xor_r ^ in_if.rx_byte;
          count_nxt = count_r + 8'd1;
          if (count_nxt >= len_r) begin
            phase_nxt = PH_CHECK;
          end
          push              = 1'b1;
          res.result_kind   = KIND_PAYLOAD;
          res.payload_byte  = in_if.rx_byte;
          res.payload_index = count_r;
        end
        PH_CHECK: begin
          check_nxt = in_if.rx_byte;
          phase_nxt = PH_END;
        end
        PH_END: begin
          push    = 1'b1;
          restart = 1'b1;
          if (in_if.rx_byte != END_BYTE) begin
            res.frame_status = ST_END_BAD;
          end else if (check_r != (xor_r ^ END_BYTE)) begin
            res.frame_status = ST_SUM_BAD;
          end else begin
            res.frame_status = ST_OK;
          end
        end
        default: begin
          phase_nxt = (in_if.rx_byte == START_BYTE) ? PH_CMD : PH_HUNT;
        end
      endcase
    end

    if (restart) begin
      phase_nxt   = PH_HUNT;
      cmd_nxt     = 8'd0;
      len_nxt     = 8'd0;
      count_nxt   = 8'd0;
      xor_nxt     = 8'd0;
      check_nxt   = 8'd0;
      elapsed_nxt = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      cmd_r     <= 8'd0;
      len_r     <= 8'd0;
      count_r   <= 8'd0;
      xor_r     <= 8'd0;
      check_r   <= 8'd0;
      elapsed_r <= 17'd0;
      limit_r   <= TIMEOUT_RST;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        cmd_r     <= cmd_nxt;
        len_r     <= len_nxt;
        count_r   <= count_nxt;
        xor_r     <= xor_nxt;
        check_r   <= check_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  sefr_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && push),
    .push_data (res),
    .has_room  (room),
    .out_if    (out_if)
  );

  // a frame end leaves the receiver hunting with a fresh timing window
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && push && res.result_kind == KIND_FINAL) |=>
      (phase_r == PH_HUNT && elapsed_r == 17'd0 && cmd_r == 8'd0))
    else $error("state not cleared after frame end");

  // payload results only carry indexes inside the declared length
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && push && res.result_kind == KIND_PAYLOAD) |->
      (res.payload_index < res.payload_length))
    else $error("payload index beyond declared length");

  // input stalls only while results wait for the sink
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with empty result queue");

endmodule

`default_nettype wire

@@ test/tb_stx_etx_frame_receiver_core.sv @@
// tb_stx_etx_frame_receiver_core: directed table and random frame traffic for the deframer,
// every result checked against the expected table row or a cycle-free predictor of the frame state
// needs sefr_pkg, sefr_in_if, sefr_out_if and stx_etx_frame_receiver_core
module tb_stx_etx_frame_receiver_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sefr_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int N_ROWS      = 28;

  typedef enum logic [2:0] {P_HUNT, P_CMD, P_LEN, P_DATA, P_CHECK, P_END} rx_phase_t;

  typedef struct packed {
    logic         is_cfg;
    logic [15:0]  limit;
    logic         op;
    logic [7:0]   rx;
    logic         typed;
    sefr_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  sefr_in_if  in_ch ();
  sefr_out_if out_ch ();

  stx_etx_frame_receiver_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // predicted frame state
  rx_phase_t   fr_phase;
  logic [7:0]  fr_cmd;
  logic [7:0]  fr_len;
  logic [7:0]  fr_count;
  logic [7:0]  fr_xor;
  logic [7:0]  fr_check;
  logic [16:0] fr_elapsed_ms;
  logic [15:0] fr_limit_ms;

  sefr_result_t pending_results [$];
  bit           failed;
  int unsigned  items_sent;
  bit           sender_burst;
  int unsigned  tick_pct;
  stim_row_t    directed_rows [N_ROWS];

  always #4 clk = ~clk;

  function automatic void new_attempt();
    fr_phase      = P_HUNT;
    fr_cmd        = 8'h00;
    fr_len        = 8'h00;
    fr_count      = 8'h00;
    fr_xor        = 8'h00;
    fr_check      = 8'h00;
    fr_elapsed_ms = '0;
  endfunction

  function automatic sefr_result_t frame_result(input logic kind, input logic [7:0] pb,
                                                input logic [7:0] idx, input sefr_status_t st);
    sefr_result_t r;
    r.result_kind    = kind;
    r.payload_byte   = pb;
    r.payload_index  = idx;
    r.frame_command  = fr_cmd;
    r.payload_length = fr_len;
    r.frame_status   = st;
    return r;
  endfunction

  // returns 1 when the request yields a result
  function automatic bit predict_frame(input logic op, input logic [7:0] b,
                                       output sefr_result_t r);
    sefr_status_t st;
    r = '0;
    if (op == OP_TICK) begin
      if (fr_elapsed_ms != ELAPSED_MAX) fr_elapsed_ms++;
      if (fr_elapsed_ms <= {1'b0, fr_limit_ms}) return 1'b0;
    end
    // a byte arriving after expiry is dropped
    if (fr_elapsed_ms > {1'b0, fr_limit_ms}) begin
      r = frame_result(KIND_FINAL, 8'h00, 8'h00, ST_TIMEOUT);
      new_attempt();
      return 1'b1;
    end
    case (fr_phase)
      P_CMD: begin
        fr_cmd   = b;
        fr_xor   = b;
        fr_phase = P_LEN;
      end
      P_LEN: begin
        fr_len   = b;
        fr_xor   = fr_xor ^ b;
        fr_count = 8'h00;
        fr_phase = (b == 8'h00) ? P_CHECK : P_DATA;
      end
      P_DATA: begin
        r        = frame_result(KIND_PAYLOAD, b, fr_count, ST_OK);
        fr_xor   = fr_xor ^ b;
        fr_count = fr_count + 8'd1;
        if (fr_count >= fr_len) fr_phase = P_CHECK;
        return 1'b1;
      end
      P_CHECK: begin
        fr_check = b;
        fr_phase = P_END;
      end
      P_END: begin
        // end byte is judged before the checksum
        if (b != END_BYTE) st = ST_END_BAD;
        else if (fr_check != (fr_xor ^ END_BYTE)) st = ST_SUM_BAD;
        else st = ST_OK;
        r = frame_result(KIND_FINAL, 8'h00, 8'h00, st);
        new_attempt();
        return 1'b1;
      end
      default: fr_phase = (b == START_BYTE) ? P_CMD : P_HUNT;
    endcase
    return 1'b0;
  endfunction

  function automatic stim_row_t req(input logic op, input logic [7:0] rx);
    stim_row_t row;
    row    = '0;
    row.op = op;
    row.rx = rx;
    return row;
  endfunction

  function automatic stim_row_t req_typed(input logic op, input logic [7:0] rx,
                                          input logic kind, input logic [7:0] pb,
                                          input logic [7:0] idx, input logic [7:0] cmd,
                                          input logic [7:0] len, input sefr_status_t st);
    stim_row_t row;
    row                    = req(op, rx);
    row.typed              = 1'b1;
    row.res.result_kind    = kind;
    row.res.payload_byte   = pb;
    row.res.payload_index  = idx;
    row.res.frame_command  = cmd;
    row.res.payload_length = len;
    row.res.frame_status   = st;
    return row;
  endfunction

  function automatic stim_row_t limit_row(input logic [15:0] v);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.limit  = v;
    return row;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic offer_request(input logic op, input logic [7:0] b);
    int unsigned gap;
    gap = (sender_burst || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_item(input logic op, input logic [7:0] b);
    sefr_result_t want;
    offer_request(op, b);
    if (predict_frame(op, b, want)) pending_results = {pending_results, want};
  endtask

  // a received byte, now and then preceded by a millisecond tick
  task automatic offer_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < tick_pct) send_item(OP_TICK, 8'($urandom));
    send_item(OP_BYTE, b);
  endtask

  task automatic write_limit(input logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a request without a result may still be in flight
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    fr_limit_ms  = v;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      failed = 1'b1;
    end
  endtask

  task automatic check_result();
    sefr_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: kind %0d byte %02h status %0d",
             out_ch.result_kind, out_ch.payload_byte, out_ch.frame_status);
      failed = 1'b1;
    end else begin
      want = pending_results.pop_front();
      check_field("result_kind", want.result_kind, out_ch.result_kind);
      check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
      check_field("payload_index", want.payload_index, out_ch.payload_index);
      check_field("frame_command", want.frame_command, out_ch.frame_command);
      check_field("payload_length", want.payload_length, out_ch.payload_length);
      check_field("frame_status", want.frame_status, out_ch.frame_status);
    end
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int unsigned hold;
    int unsigned seen;
    bit          squeezed;
    bit          calm;
    hold         = 0;
    seen         = 0;
    squeezed     = 1'b0;
    calm         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_result();
        seen++;
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!squeezed && seen >= 150 && in_ch.valid) begin
        // hold off long enough for the result queue to fill and stall requests
        squeezed      = 1'b1;
        hold          = 300;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        hold          = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    stim_row_t    row;
    sefr_result_t want;
    logic [15:0]  lim;
    logic [7:0]   cmd;
    logic [7:0]   len;
    logic [7:0]   sum;
    logic [7:0]   b;
    int unsigned  phase_no;
    int unsigned  phase_end;
    int unsigned  r;
    int unsigned  k;
    int           i;
    int           j;
    bit           long_done;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_BYTE;
    in_ch.rx_byte = 8'h00;
    failed        = 1'b0;
    items_sent    = 0;
    sender_burst  = 1'b0;
    tick_pct      = 5;
    long_done     = 1'b0;

    directed_rows = '{
      req(OP_TICK, 8'hFF),
      req(OP_BYTE, 8'h00),
      // zero length frame, checksum right after the length
      req(OP_BYTE, START_BYTE),
      req(OP_BYTE, 8'h00),
      req(OP_BYTE, 8'h00),
      req(OP_BYTE, 8'h55),
      req_typed(OP_BYTE, END_BYTE, KIND_FINAL, 8'h00, 8'h00, 8'h00, 8'h00, ST_OK),
      // bad end byte wins over a bad checksum
      req(OP_BYTE, START_BYTE),
      req(OP_BYTE, 8'hFF),
      req(OP_BYTE, 8'h02),
      req_typed(OP_BYTE, 8'hFF, KIND_PAYLOAD, 8'hFF, 8'h00, 8'hFF, 8'h02, ST_OK),
      req_typed(OP_BYTE, 8'h00, KIND_PAYLOAD, 8'h00, 8'h01, 8'hFF, 8'h02, ST_OK),
      req(OP_BYTE, 8'h00),
      req_typed(OP_BYTE, 8'h00, KIND_FINAL, 8'h00, 8'h00, 8'hFF, 8'h02, ST_END_BAD),
      // good end byte, wrong checksum
      req(OP_BYTE, START_BYTE),
      req(OP_BYTE, 8'h12),
      req(OP_BYTE, 8'h01),
      req(OP_BYTE, 8'h80),
      req(OP_BYTE, 8'h00),
      req_typed(OP_BYTE, END_BYTE, KIND_FINAL, 8'h00, 8'h00, 8'h12, 8'h01, ST_SUM_BAD),
      // timeout while hunting
      limit_row(16'h0000),
      req_typed(OP_TICK, 8'h00, KIND_FINAL, 8'h00, 8'h00, 8'h00, 8'h00, ST_TIMEOUT),
      // limit lowered below the elapsed time, next byte is dropped
      limit_row(TIMEOUT_RST),
      req(OP_BYTE, START_BYTE),
      req(OP_BYTE, 8'h33),
      req(OP_TICK, 8'h00),
      limit_row(16'h0000),
      req_typed(OP_BYTE, 8'h44, KIND_FINAL, 8'h00, 8'h00, 8'h33, 8'h00, ST_TIMEOUT)
    };

    repeat (6) @(posedge clk);
    rst_n       <= 1'b1;
    fr_limit_ms  = TIMEOUT_RST;
    new_attempt();

    for (i = 0; i < N_ROWS; i++) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        write_limit(row.limit);
      end else if (row.typed) begin
        offer_request(row.op, row.rx);
        void'(predict_frame(row.op, row.rx, want));
        pending_results = {pending_results, row.res};
      end else begin
        send_item(row.op, row.rx);
      end
    end

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      case (phase_no)
        0: lim = 16'hFFFF;
        1: lim = 16'h0000;
        default: begin
          if (r < 2) lim = 16'($urandom);
          else if (r < 4) lim = TIMEOUT_RST;
          else lim = 16'($urandom_range(3, 80));
        end
      endcase
      write_limit(lim);
      sender_burst = ($urandom_range(0, 4) == 0);
      tick_pct     = $urandom_range(2, 15);
      phase_end    = items_sent + 110;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        r = $urandom_range(0, 99);
        if (r < 72 || !long_done) begin
          // frame with random content, now and then with a bad checksum or end byte
          r = $urandom_range(0, 99);
          if (!long_done || r < 1) len = 8'hFF;
          else if (r < 11) len = 8'($urandom_range(7, 30));
          else len = 8'($urandom_range(0, 6));
          long_done = 1'b1;
          cmd = 8'($urandom);
          sum = cmd ^ len ^ END_BYTE;
          offer_byte(START_BYTE);
          offer_byte(cmd);
          offer_byte(len);
          for (j = 0; j < len; j++) begin
            b   = 8'($urandom);
            sum = sum ^ b;
            offer_byte(b);
          end
          if ($urandom_range(0, 99) < 12) sum = sum ^ 8'($urandom_range(1, 255));
          offer_byte(sum);
          offer_byte(($urandom_range(0, 99) < 10) ? 8'($urandom) : END_BYTE);
        end else if (r < 87) begin
          // line noise, sometimes a stray start byte
          k = $urandom_range(1, 6);
          repeat (k) begin
            b = ($urandom_range(0, 7) == 0) ? START_BYTE : 8'($urandom);
            offer_byte(b);
          end
        end else begin
          // truncated frame, the next one gets swallowed into it
          offer_byte(START_BYTE);
          offer_byte(8'($urandom));
          len = 8'($urandom_range(1, 12));
          offer_byte(len);
          k = $urandom_range(0, len - 1);
          for (j = 0; j < k; j++) offer_byte(8'($urandom));
        end
      end
      phase_no++;
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
